/* hdl/rcsmt_pkg.sv */
// ---------------------------------------------------------------------------
// rcsmt_pkg
// Shared types and constants of the candidate select and median tracker.
// ---------------------------------------------------------------------------
package rcsmt_pkg;

    localparam int COORD_W = 12;
    localparam int NUM_C   = 4;
    localparam int QUOT_W  = COORD_W + 16;
    localparam int PROD_W  = 2 * QUOT_W;
    localparam int DIST_W  = 36;
    localparam int ACC_W   = DIST_W + 2;
    localparam int LIMIT_W = 32;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_DEF_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_DEF_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_DEF_W = 3'd2;
    localparam logic [IDX_W-1:0] REG_DEF_H = 3'd3;
    localparam logic [IDX_W-1:0] REG_LIMIT = 3'd4;

    localparam logic [COORD_W-1:0] RST_DEF_X = 12'd68;
    localparam logic [COORD_W-1:0] RST_DEF_Y = 12'd39;
    localparam logic [COORD_W-1:0] RST_DEF_W = 12'd100;
    localparam logic [COORD_W-1:0] RST_DEF_H = 12'd180;
    localparam logic [LIMIT_W-1:0] RST_LIMIT = 32'd206955594;

    localparam logic [DIST_W-1:0] DIST_SAT = {DIST_W{1'b1}};

    // coordinate order x, y, w, h
    typedef logic [NUM_C-1:0][COORD_W-1:0] rect_t;

    typedef struct packed {
        logic load;
        logic step;
    } cell_ctl_t;

endpackage

/* hdl/roi_candidate_select_median_tracker_unit.sv */
// ---------------------------------------------------------------------------
// roi_candidate_select_median_tracker_unit
// Best candidate per frame by relative distance, history window medians.
// ---------------------------------------------------------------------------
// channel  | dir | tdata                          | tlast      | tuser
// s_       | in  | cand x,y,w,h                   | frame_last | frame_empty
// m_       | out | active x..h, median x..h, max  | -          | accepted
// cfg_     | in  | default x,y,w,h, dist_sq_limit | -          | -
//
// a candidate word passes the accepting idle state, the divider steps, the square/sum
// steps and the update; a word with frame_last then loads and rotates the held entries
// through the window cells and finishes, an empty frame goes straight to load, rotation, finish
// reset is synchronous; the window returns to one entry holding the default
// the input stalls while a word is worked; a finished result waits in the
// output register and the next word is taken meanwhile, a frame end waits
// ---------------------------------------------------------------------------
module roi_candidate_select_median_tracker_unit #(
    parameter int HISTORY_SLOTS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // cand_x, cand_y, cand_w, cand_h
    input  logic         s_tlast,
    input  logic         s_tuser,   // frame_empty
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // active_x..h, median_x..h, max_top, pad
    output logic         m_tuser,   // accepted
    input  logic         cfg_we,
    input  logic [2:0]   cfg_idx,
    input  logic [31:0]  cfg_data
);
    import rcsmt_pkg::*;

    localparam int W  = HISTORY_SLOTS - 1;
    localparam int CW = $clog2(HISTORY_SLOTS);
    localparam int IW = (W > 1) ? $clog2(W) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_SQ, S_UPD, S_LOAD, S_ROT, S_FIN
    } state_t;

    state_t               state_reg;
    rect_t                dflt_reg;
    logic [LIMIT_W-1:0]   limit_reg;
    rect_t                cand_reg;
    logic                 last_reg;
    logic [4:0]           div_cnt_reg;
    logic [2:0]           sq_cnt_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic                 prod_sat_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [DIST_W-1:0]    best_reg;
    rect_t                brect_reg;
    rect_t                active_reg;
    logic                 acc_flag_reg;
    logic                 pristine_reg;
    logic [CW-1:0]        cnt_reg;
    logic [CW-1:0]        rot_reg;
    logic [COORD_W-1:0]   max_reg;
    logic                 m_valid_reg;
    logic [111:0]         m_data_reg;
    logic                 m_user_reg;

    logic                 start;
    logic                 div_step;
    logic [NUM_C-1:0][QUOT_W-1:0] quot;
    logic [NUM_C-1:0]     zdiv;
    rect_t                cand_in;

    assign cand_in  = s_tdata;
    assign start    = s_tvalid && s_tready;
    assign div_step = (state_reg == S_DIV);

    for (genvar c = 0; c < NUM_C; c++) begin : g_div
        rcsmt_div u_div (
            .aclk     (aclk),
            .start    (start),
            .step     (div_step),
            .coord    (cand_in[c]),
            .dflt     (dflt_reg[c]),
            .quot     (quot[c]),
            .zero_div (zdiv[c])
        );
    end

    // distance of the current candidate and the frame best after it
    logic [DIST_W-1:0] term;
    logic [DIST_W-1:0] sum;
    logic [DIST_W-1:0] nbest;
    rect_t             nrect;
    logic              take;

    assign term  = (prod_sat_reg || prod_reg[PROD_W-1:DIST_W] != '0)
                   ? DIST_SAT : prod_reg[DIST_W-1:0];
    assign sum   = (acc_reg[ACC_W-1:DIST_W] != '0) ? DIST_SAT : acc_reg[DIST_W-1:0];
    assign nbest = (sum < best_reg) ? sum : best_reg;
    assign nrect = (sum < best_reg) ? cand_reg : brect_reg;
    assign take  = nbest < {{(DIST_W-LIMIT_W){1'b0}}, limit_reg};

    // window chain
    cell_ctl_t        ctl;
    logic             shift;
    logic             cfg_def;
    rect_t            patched;
    rect_t            own   [W];
    rect_t            trav  [W];
    logic [NUM_C-1:0][CW-1:0] lt [W];
    logic [NUM_C-1:0][CW-1:0] le [W];
    rect_t            rst0;

    assign ctl.load = (state_reg == S_LOAD);
    assign ctl.step = (state_reg == S_ROT);
    assign shift    = (state_reg == S_UPD) && last_reg && take;
    assign cfg_def  = cfg_we && pristine_reg && (cfg_idx < REG_LIMIT);
    assign rst0     = {RST_DEF_H, RST_DEF_W, RST_DEF_Y, RST_DEF_X};

    always_comb begin
        patched = own[0];
        patched[cfg_idx[1:0]] = cfg_data[COORD_W-1:0];
    end

    for (genvar k = 0; k < W; k++) begin : g_cell
        if (k == 0) begin : g_head
            rcsmt_cell #(.CW(CW)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctl      (ctl),
                .own_we   (shift || cfg_def),
                .own_in   (shift ? nrect : patched),
                .own_rst  (rst0),
                .trav_in  (trav[IW'(cnt_reg - CW'(1))]),
                .own_out  (own[k]),
                .trav_out (trav[k]),
                .lt_cnt   (lt[k]),
                .le_cnt   (le[k])
            );
        end else begin : g_body
            rcsmt_cell #(.CW(CW)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctl      (ctl),
                .own_we   (shift),
                .own_in   (own[k-1]),
                .own_rst  ('0),
                .trav_in  (trav[k-1]),
                .own_out  (own[k]),
                .trav_out (trav[k]),
                .lt_cnt   (lt[k]),
                .le_cnt   (le[k])
            );
        end
    end

    // upper median: the entry whose rank range covers n/2
    logic [CW-1:0] half;
    rect_t         med;

    assign half = cnt_reg >> 1;

    always_comb begin
        med = '0;
        for (int k = 0; k < W; k++) begin
            for (int c = 0; c < NUM_C; c++) begin
                if (CW'(k) < cnt_reg && lt[k][c] <= half && half < le[k][c]) begin
                    med[c] = med[c] | own[k][c];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            dflt_reg     <= rst0;
            limit_reg    <= RST_LIMIT;
            best_reg     <= DIST_SAT;
            brect_reg    <= '0;
            active_reg   <= '0;
            acc_flag_reg <= 1'b0;
            pristine_reg <= 1'b1;
            cnt_reg      <= CW'(1);
            m_valid_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && state_reg != S_FIN) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_idx)
                    REG_DEF_X: dflt_reg[0] <= cfg_data[COORD_W-1:0];
                    REG_DEF_Y: dflt_reg[1] <= cfg_data[COORD_W-1:0];
                    REG_DEF_W: dflt_reg[2] <= cfg_data[COORD_W-1:0];
                    REG_DEF_H: dflt_reg[3] <= cfg_data[COORD_W-1:0];
                    REG_LIMIT: limit_reg   <= cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        cand_reg     <= cand_in;
                        last_reg     <= s_tlast;
                        div_cnt_reg  <= '0;
                        acc_flag_reg <= 1'b0;
                        state_reg    <= s_tuser ? S_LOAD : S_DIV;
                    end
                end
                S_DIV: begin
                    div_cnt_reg <= div_cnt_reg + 5'd1;
                    if (div_cnt_reg == 5'(QUOT_W - 1)) begin
                        sq_cnt_reg <= '0;
                        acc_reg    <= '0;
                        state_reg  <= S_SQ;
                    end
                end
                S_SQ: begin
                    sq_cnt_reg <= sq_cnt_reg + 3'd1;
                    if (sq_cnt_reg != 3'd0) begin
                        acc_reg <= acc_reg + {{(ACC_W-DIST_W){1'b0}}, term};
                    end
                    if (sq_cnt_reg < 3'(NUM_C)) begin
                        prod_reg     <= quot[sq_cnt_reg[1:0]] * quot[sq_cnt_reg[1:0]];
                        prod_sat_reg <= zdiv[sq_cnt_reg[1:0]];
                    end else begin
                        state_reg <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (last_reg) begin
                        best_reg  <= DIST_SAT;
                        brect_reg <= '0;
                        if (take) begin
                            acc_flag_reg <= 1'b1;
                            active_reg   <= nrect;
                            pristine_reg <= 1'b0;
                            if (cnt_reg < CW'(W)) begin
                                cnt_reg <= cnt_reg + CW'(1);
                            end
                        end
                        state_reg <= S_LOAD;
                    end else begin
                        best_reg  <= nbest;
                        brect_reg <= nrect;
                        state_reg <= S_IDLE;
                    end
                end
                S_LOAD: begin
                    rot_reg   <= '0;
                    max_reg   <= '0;
                    state_reg <= S_ROT;
                end
                S_ROT: begin
                    rot_reg <= rot_reg + CW'(1);
                    if (trav[0][1] > max_reg) begin
                        max_reg <= trav[0][1];
                    end
                    if (rot_reg == cnt_reg - CW'(1)) begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {4'd0, max_reg, med, active_reg};
                        m_user_reg  <= acc_flag_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != '0 && cnt_reg <= CW'(W))
        else $error("window count out of range");

    a_pristine_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        !pristine_reg |=> !pristine_reg)
        else $error("pristine flag set again");

    a_acc_not_pristine: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> !pristine_reg)
        else $error("accepted reported while window untouched");

    a_shift_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        shift |=> state_reg == S_LOAD)
        else $error("window shifted outside frame end");

endmodule

/* hdl/rcsmt_div.sv */
// ---------------------------------------------------------------------------
// rcsmt_div
// One bit per cycle (while step is high) restoring divider for |c - d| * 65536 / d.
// ---------------------------------------------------------------------------
module rcsmt_div (
    input  logic                          aclk,
    input  logic                          start,
    input  logic                          step,
    input  logic [rcsmt_pkg::COORD_W-1:0] coord,
    input  logic [rcsmt_pkg::COORD_W-1:0] dflt,
    output logic [rcsmt_pkg::QUOT_W-1:0]  quot,
    output logic                          zero_div
);
    import rcsmt_pkg::*;

    logic [COORD_W-1:0] diff;
    logic [COORD_W:0]   rem_reg;
    logic [COORD_W:0]   shifted;
    logic [QUOT_W-1:0]  dq_reg;
    logic [COORD_W-1:0] d_reg;
    logic               ge;

    assign diff    = (coord >= dflt) ? (coord - dflt) : (dflt - coord);
    assign shifted = {rem_reg[COORD_W-1:0], dq_reg[QUOT_W-1]};
    assign ge      = shifted >= {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dq_reg  <= {diff, 16'd0};
            d_reg   <= dflt;
        end else if (step) begin
            rem_reg <= ge ? (shifted - {1'b0, d_reg}) : shifted;
            dq_reg  <= {dq_reg[QUOT_W-2:0], ge};
        end
    end

    assign quot     = dq_reg;
    assign zero_div = (d_reg == '0);

endmodule

/* hdl/rcsmt_cell.sv */
// ---------------------------------------------------------------------------
// rcsmt_cell
// One window slot: stored rectangle, circulating copy and rank counters.
// ---------------------------------------------------------------------------
module rcsmt_cell #(
    parameter int CW = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rcsmt_pkg::cell_ctl_t ctl,
    input  logic                 own_we,
    input  rcsmt_pkg::rect_t     own_in,
    input  rcsmt_pkg::rect_t     own_rst,
    input  rcsmt_pkg::rect_t     trav_in,
    output rcsmt_pkg::rect_t     own_out,
    output rcsmt_pkg::rect_t     trav_out,
    output logic [rcsmt_pkg::NUM_C-1:0][CW-1:0] lt_cnt,
    output logic [rcsmt_pkg::NUM_C-1:0][CW-1:0] le_cnt
);
    import rcsmt_pkg::*;

    rect_t                   own_reg;
    rect_t                   trav_reg;
    logic [NUM_C-1:0][CW-1:0] lt_reg;
    logic [NUM_C-1:0][CW-1:0] le_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_reg <= own_rst;
        end else if (own_we) begin
            own_reg <= own_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            trav_reg <= own_reg;
            lt_reg   <= '0;
            le_reg   <= '0;
        end else if (ctl.step) begin
            trav_reg <= trav_in;
            for (int c = 0; c < NUM_C; c++) begin
                lt_reg[c] <= lt_reg[c] + CW'(trav_reg[c] < own_reg[c]);
                le_reg[c] <= le_reg[c] + CW'(trav_reg[c] <= own_reg[c]);
            end
        end
    end

    assign own_out  = own_reg;
    assign trav_out = trav_reg;
    assign lt_cnt   = lt_reg;
    assign le_cnt   = le_reg;

endmodule
